// ===== hw/rtl/dsg_pkg.sv =====
// Shared types and constants of the filled disc span generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package dsg_pkg;

    localparam int IN_W      = 17;   // center coordinate input width
    localparam int COORD_W   = 19;   // signed internal coordinate width
    localparam int SPAN_W    = 10;   // row and column output width
    localparam int COLOR_W   = 8;
    localparam int RADIUS_W  = 5;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic load;
        logic issue;
    } dsg_cmd_t;

    typedef struct packed {
        logic last_row;
        logic flush;
    } dsg_status_t;

endpackage

// ===== hw/rtl/dsg_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, one row per cycle.
// Carries the row coordinate and valid/tail flags alongside; no package needed.
module dsg_isqrt_pipe #(
    parameter int RW = 5,
    parameter int PW = 19
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_tail,
    input  logic [2*RW-1:0]      in_n,
    input  logic signed [PW-1:0] in_py,
    output logic                 out_valid,
    output logic                 out_tail,
    output logic [RW-1:0]        out_root,
    output logic signed [PW-1:0] out_py
);

    logic [RW:0]          valid_reg;
    logic [RW:0]          tail_reg;
    logic [2*RW-1:0]      n_reg   [0:RW];
    logic signed [PW-1:0] py_reg  [0:RW];
    logic [RW-1:0]        acc_reg [1:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[RW-1:0], in_valid};
            tail_reg  <= {tail_reg[RW-1:0], in_tail};
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg[0]  <= in_n;
        py_reg[0] <= in_py;
    end

    // Stage s decides root bit RW-s: keep the candidate if its square still fits.
    for (genvar s = 1; s <= RW; s++)
    begin : g_stage
        logic [RW-1:0]   prev;
        logic [RW-1:0]   cand;
        logic [2*RW-1:0] sq;

        if (s == 1)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = acc_reg[s-1];
        end

        assign cand = prev | (RW'(1) << (RW - s));
        assign sq   = (2*RW)'(cand) * (2*RW)'(cand);

        always_ff @(posedge clk)
        begin
            acc_reg[s] <= (sq <= n_reg[s-1]) ? cand : prev;
            n_reg[s]   <= n_reg[s-1];
            py_reg[s]  <= py_reg[s-1];
        end
    end

    assign out_valid = valid_reg[RW];
    assign out_tail  = tail_reg[RW];
    assign out_root  = acc_reg[RW];
    assign out_py    = py_reg[RW];

`ifndef SYNTHESIS
    // Only one point is in flight, so at most one tail row is in the pipe.
    a_one_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg & tail_reg) <= 1)
        else $error("more than one tail row in the root pipe");
`endif

endmodule

// ===== hw/rtl/dsg_datapath.sv =====
// Datapath: center rounding, row counter, square root pipe, clipping and span output.
// Depends on dsg_pkg and dsg_isqrt_pipe.
module dsg_datapath #(
    parameter int FRAME_MAX     = 1024,
    parameter int RADIUS_MAX    = 31,
    parameter int FRACTION_BITS = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dsg_pkg::dsg_cmd_t                     cmd,
    output dsg_pkg::dsg_status_t                  status,
    input  logic signed [dsg_pkg::IN_W-1:0]       center_x,
    input  logic signed [dsg_pkg::IN_W-1:0]       center_y,
    input  logic [dsg_pkg::COLOR_W-1:0]           color_red,
    input  logic [dsg_pkg::COLOR_W-1:0]           color_green,
    input  logic [dsg_pkg::COLOR_W-1:0]           color_blue,
    input  logic [dsg_pkg::RADIUS_W-1:0]          cfg_radius,
    input  logic [dsg_pkg::CFG_W-1:0]             cfg_width,
    input  logic [dsg_pkg::CFG_W-1:0]             cfg_height,
    output logic                                  span_valid,
    output logic [dsg_pkg::SPAN_W-1:0]            span_row,
    output logic [dsg_pkg::SPAN_W-1:0]            span_first,
    output logic [dsg_pkg::SPAN_W-1:0]            span_final,
    output logic [dsg_pkg::COLOR_W-1:0]           span_red,
    output logic [dsg_pkg::COLOR_W-1:0]           span_green,
    output logic [dsg_pkg::COLOR_W-1:0]           span_blue,
    output logic                                  final_span
);
    import dsg_pkg::*;

    localparam int RW      = $clog2(RADIUS_MAX + 1);
    localparam int NW      = 2 * RW;
    localparam int DW      = RW + 1;
    localparam int HALF    = (FRACTION_BITS == 0) ? 0 : (1 << (FRACTION_BITS - 1));
    localparam int NEG_ADD = (1 << FRACTION_BITS) - 1 - HALF;

    localparam logic signed [COORD_W-1:0] HALF_C    = COORD_W'(HALF);
    localparam logic signed [COORD_W-1:0] NEG_C     = COORD_W'(NEG_ADD);
    localparam logic signed [COORD_W-1:0] FRAME_LIM = COORD_W'(FRAME_MAX);
    localparam logic signed [COORD_W-1:0] ONE_C     = COORD_W'(1);
    localparam logic [RADIUS_W-1:0]       RADIUS_LIM = RADIUS_W'(RADIUS_MAX);
    localparam logic [RADIUS_W-1:0]       RADIUS_ONE = RADIUS_W'(1);

    // Point registers, loaded when a word is accepted.
    logic signed [COORD_W-1:0] cx_reg, cy_reg, w_reg, h_reg;
    logic [RW-1:0]             r_reg;
    logic [NW-1:0]             rsq_reg;
    logic [COLOR_W-1:0]        red_reg, green_reg, blue_reg;
    logic signed [DW-1:0]      dy_reg;

    logic signed [COORD_W-1:0] cx_ext, cy_ext, cx_round, cy_round;
    logic signed [COORD_W-1:0] w_ext, h_ext, w_sat, h_sat;
    logic [RADIUS_W-1:0]       r_sat;
    logic [RW-1:0]             r_eff;
    logic [NW-1:0]             rsq_load;

    // Half away from zero: add half for positive, (one - half - ulp) for negative,
    // then an arithmetic shift floors the result.
    always_comb
    begin
        cx_ext   = {{(COORD_W-IN_W){center_x[IN_W-1]}}, center_x};
        cy_ext   = {{(COORD_W-IN_W){center_y[IN_W-1]}}, center_y};
        cx_round = (cx_ext + (cx_ext[COORD_W-1] ? NEG_C : HALF_C)) >>> FRACTION_BITS;
        cy_round = (cy_ext + (cy_ext[COORD_W-1] ? NEG_C : HALF_C)) >>> FRACTION_BITS;
        w_ext    = COORD_W'(cfg_width);
        h_ext    = COORD_W'(cfg_height);
        w_sat    = (w_ext > FRAME_LIM) ? FRAME_LIM : w_ext;
        h_sat    = (h_ext > FRAME_LIM) ? FRAME_LIM : h_ext;
        r_sat    = (cfg_radius > RADIUS_LIM) ? RADIUS_LIM : cfg_radius;
        r_eff    = (r_sat == RADIUS_ONE) ? '0 : RW'(r_sat);
        rsq_load = NW'(r_eff) * NW'(r_eff);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg    <= cx_round;
            cy_reg    <= cy_round;
            w_reg     <= w_sat;
            h_reg     <= h_sat;
            r_reg     <= r_eff;
            rsq_reg   <= rsq_load;
            red_reg   <= color_red;
            green_reg <= color_green;
            blue_reg  <= color_blue;
            dy_reg    <= -$signed({1'b0, r_eff});
        end
        else if (cmd.issue)
        begin
            dy_reg <= dy_reg + DW'(1);
        end
    end

    // Row issue: remaining square r*r - dy*dy and the frame row of this offset.
    logic [RW-1:0]             ady;
    logic [NW-1:0]             n_issue;
    logic signed [COORD_W-1:0] py_issue;
    logic                      last_row;

    always_comb
    begin
        ady      = dy_reg[DW-1] ? RW'(-dy_reg) : RW'(dy_reg);
        n_issue  = rsq_reg - (NW'(ady) * NW'(ady));
        py_issue = cy_reg + {{(COORD_W-DW){dy_reg[DW-1]}}, dy_reg};
        last_row = (dy_reg == $signed({1'b0, r_reg}));
    end

    logic                      pv, ptail;
    logic [RW-1:0]             proot;
    logic signed [COORD_W-1:0] ppy;

    dsg_isqrt_pipe #(
        .RW (RW),
        .PW (COORD_W)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.issue),
        .in_tail   (last_row),
        .in_n      (n_issue),
        .in_py     (py_issue),
        .out_valid (pv),
        .out_tail  (ptail),
        .out_root  (proot),
        .out_py    (ppy)
    );

    // Clipping of the row leaving the root pipe.
    logic signed [COORD_W-1:0] hw_ext, first_c, last_c, w_m1, first_clip, last_clip;
    logic                      keep;

    always_comb
    begin
        hw_ext     = COORD_W'(proot);
        first_c    = cx_reg - hw_ext;
        last_c     = cx_reg + hw_ext;
        w_m1       = w_reg - ONE_C;
        keep       = pv && (ppy >= 0) && (ppy < h_reg) && (last_c >= 0) && (first_c < w_reg);
        first_clip = (first_c < 0) ? '0 : first_c;
        last_clip  = (last_c > w_m1) ? w_m1 : last_c;
    end

    // One span is held back until the next kept row or the end of the point,
    // so that the last span can be flagged.
    logic                pend_v_reg, pend_v_next;
    logic                flush_reg;
    logic [SPAN_W-1:0]   pend_row_reg, pend_first_reg, pend_last_reg;
    logic                strobe_reg, strobe_next;
    logic                out_last_reg, out_last_next;
    logic [SPAN_W-1:0]   orow_reg, ofirst_reg, olast_reg;
    logic [COLOR_W-1:0]  ored_reg, ogreen_reg, oblue_reg;

    always_comb
    begin
        strobe_next   = 1'b0;
        out_last_next = 1'b0;
        pend_v_next   = pend_v_reg;
        if (keep)
        begin
            strobe_next = pend_v_reg;
            pend_v_next = 1'b1;
        end
        else if (flush_reg)
        begin
            strobe_next   = pend_v_reg;
            out_last_next = 1'b1;
            pend_v_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg   <= 1'b0;
            flush_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            pend_v_reg   <= pend_v_next;
            flush_reg    <= pv && ptail;
            strobe_reg   <= strobe_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            pend_row_reg   <= ppy[SPAN_W-1:0];
            pend_first_reg <= first_clip[SPAN_W-1:0];
            pend_last_reg  <= last_clip[SPAN_W-1:0];
        end
        if (strobe_next)
        begin
            orow_reg   <= pend_row_reg;
            ofirst_reg <= pend_first_reg;
            olast_reg  <= pend_last_reg;
            ored_reg   <= red_reg;
            ogreen_reg <= green_reg;
            oblue_reg  <= blue_reg;
        end
    end

    assign status.last_row = last_row;
    assign status.flush    = flush_reg;

    assign span_valid = strobe_reg;
    assign span_row   = orow_reg;
    assign span_first = ofirst_reg;
    assign span_final = olast_reg;
    assign span_red   = ored_reg;
    assign span_green = ogreen_reg;
    assign span_blue  = oblue_reg;
    assign final_span = strobe_reg & out_last_reg;

`ifndef SYNTHESIS
    // The flagged span empties the holding register at the same edge.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && out_last_reg) |-> !pend_v_reg)
        else $error("held span left behind after the final span");

    // The row counter never runs past the radius while rows are issued.
    a_dy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (dy_reg <= $signed({1'b0, r_reg})))
        else $error("row offset issued beyond the radius");
`endif

endmodule

// ===== hw/rtl/dsg_ctrl.sv =====
// Controller state machine: accepts a point, issues its rows, waits for the flush.
// Depends on dsg_pkg for the command and status structs.
module dsg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dsg_pkg::dsg_status_t status,
    output dsg_pkg::dsg_cmd_t    cmd
);
    import dsg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } dsg_state_t;

    dsg_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.issue  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_row)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.flush)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    // The end-of-point flush only arrives after all rows have been issued.
    a_flush_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.flush |-> (state_reg == ST_WAIT))
        else $error("flush seen outside the wait state");
`endif

endmodule

// ===== hw/rtl/filled_disc_span_generator.sv =====
// Filled disc span generator: one colored point in, at most one clipped span per disc row out.
// An accepted point with effective radius r (a radius of 1 counts as 0) keeps busy high
// while its rows are issued, one row per cycle, into the square root pipe and until the
// last row has left the pipe and been flushed; spans cannot stall.
// Reset (rst_n low, asynchronous) returns to idle and loads radius 1 and a 640 x 480 frame.
module filled_disc_span_generator #(
    parameter int FRAME_MAX     = 1024,
    parameter int RADIUS_MAX    = 31,
    parameter int FRACTION_BITS = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [dsg_pkg::IN_W-1:0]       center_x,
    input  logic signed [dsg_pkg::IN_W-1:0]       center_y,
    input  logic [dsg_pkg::COLOR_W-1:0]           color_red,
    input  logic [dsg_pkg::COLOR_W-1:0]           color_green,
    input  logic [dsg_pkg::COLOR_W-1:0]           color_blue,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dsg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dsg_pkg::CFG_W-1:0]             cfg_data,
    output logic                                  span_valid,
    output logic [dsg_pkg::SPAN_W-1:0]            span_row,
    output logic [dsg_pkg::SPAN_W-1:0]            span_first,
    output logic [dsg_pkg::SPAN_W-1:0]            span_final,
    output logic [dsg_pkg::COLOR_W-1:0]           span_red,
    output logic [dsg_pkg::COLOR_W-1:0]           span_green,
    output logic [dsg_pkg::COLOR_W-1:0]           span_blue,
    output logic                                  final_span
);
    import dsg_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic [CFG_W-1:0]    width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_W'(1);
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic        accept;
    dsg_cmd_t    cmd;
    dsg_status_t status;

    assign accept = start && !busy;

    dsg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    dsg_datapath #(
        .FRAME_MAX     (FRAME_MAX),
        .RADIUS_MAX    (RADIUS_MAX),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .center_x    (center_x),
        .center_y    (center_y),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .cfg_radius  (radius_reg),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .span_valid  (span_valid),
        .span_row    (span_row),
        .span_first  (span_first),
        .span_final  (span_final),
        .span_red    (span_red),
        .span_green  (span_green),
        .span_blue   (span_blue),
        .final_span  (final_span)
    );

endmodule

// ===== dv/filled_disc_span_generator_tb.sv =====
// Self-checking testbench for filled_disc_span_generator: directed table, then random phases.
// Predicts disc spans from its own model of rounding, disc rows and frame clipping,
// or takes them from the directed table. Depends on dsg_pkg and the filled_disc_span_generator RTL.
module filled_disc_span_generator_tb;
    import dsg_pkg::*;

    localparam int FRAME_LIMIT  = 1024;
    localparam int RADIUS_LIMIT = 31;
    localparam int SUB_PIXEL    = 16;
    localparam int POINTS_PER_PHASE = 45;
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE_CYCLES = 75;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [SPAN_W-1:0]  row;
        logic [SPAN_W-1:0]  first;
        logic [SPAN_W-1:0]  last;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               fin;
    } disc_span_t;

    typedef enum {SPANS_PREDICTED, SPANS_NONE, SPANS_ONE} span_check_t;

    typedef struct {
        bit                       is_write;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [CFG_W-1:0]         reg_value;
        logic signed [IN_W-1:0]   cx;
        logic signed [IN_W-1:0]   cy;
        logic [COLOR_W-1:0]       red;
        logic [COLOR_W-1:0]       green;
        logic [COLOR_W-1:0]       blue;
        span_check_t              check;
        int                       row;
        int                       first;
        int                       last;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [IN_W-1:0] center_x;
    logic signed [IN_W-1:0] center_y;
    logic [COLOR_W-1:0]     color_red;
    logic [COLOR_W-1:0]     color_green;
    logic [COLOR_W-1:0]     color_blue;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   span_valid;
    logic [SPAN_W-1:0]      span_row;
    logic [SPAN_W-1:0]      span_first;
    logic [SPAN_W-1:0]      span_final;
    logic [COLOR_W-1:0]     span_red;
    logic [COLOR_W-1:0]     span_green;
    logic [COLOR_W-1:0]     span_blue;
    logic                   final_span;

    // Shadow copy of the block's registers, reset values included.
    logic [RADIUS_W-1:0] radius_q = 5'd1;
    logic [CFG_W-1:0]    width_q  = 11'd640;
    logic [CFG_W-1:0]    height_q = 11'd480;

    disc_span_t pending_spans[$];
    stim_row_t  stim_table[$];
    int         error_count   = 0;
    int         points_sent   = 0;
    int         spans_checked = 0;
    int         reg_writes    = 0;

    filled_disc_span_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .center_x    (center_x),
        .center_y    (center_y),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .span_valid  (span_valid),
        .span_row    (span_row),
        .span_first  (span_first),
        .span_final  (span_final),
        .span_red    (span_red),
        .span_green  (span_green),
        .span_blue   (span_blue),
        .final_span  (final_span)
    );

    always #1 clk = ~clk;

    // Nearest pixel, halves away from zero.
    function automatic int round_to_pixel(input logic signed [IN_W-1:0] v);
        int s;
        s = int'(v);
        if (s >= 0)
            return (s + SUB_PIXEL / 2) / SUB_PIXEL;
        return -((-s + SUB_PIXEL / 2) / SUB_PIXEL);
    endfunction

    function automatic int int_sqrt(input int n);
        int k;
        k = 0;
        while ((k + 1) * (k + 1) <= n)
            k++;
        return k;
    endfunction

    function automatic void predict_disc_spans(input logic signed [IN_W-1:0] cx_in, cy_in,
                                               input logic [COLOR_W-1:0] red, green, blue);
        int cx, cy, w, h, r, py, hw, lo, hi, made;
        disc_span_t s;
        cx = round_to_pixel(cx_in);
        cy = round_to_pixel(cy_in);
        w = (width_q > FRAME_LIMIT) ? FRAME_LIMIT : int'(width_q);
        h = (height_q > FRAME_LIMIT) ? FRAME_LIMIT : int'(height_q);
        r = (radius_q > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(radius_q);
        if (r == 1)
            r = 0;
        made = 0;
        for (int dy = -r; dy <= r; dy++)
        begin
            py = cy + dy;
            if (py < 0 || py >= h)
                continue;
            hw = int_sqrt(r * r - dy * dy);
            lo = cx - hw;
            hi = cx + hw;
            if (hi < 0 || lo >= w)
                continue;
            if (lo < 0)
                lo = 0;
            if (hi > w - 1)
                hi = w - 1;
            s.row   = py[SPAN_W-1:0];
            s.first = lo[SPAN_W-1:0];
            s.last  = hi[SPAN_W-1:0];
            s.red   = red;
            s.green = green;
            s.blue  = blue;
            s.fin   = 1'b0;
            pending_spans.push_back(s);
            made++;
        end
        if (made > 0)
            pending_spans[pending_spans.size() - 1].fin = 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input disc_span_t want,
                                          input disc_span_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%s: expected row %0d cols %0d..%0d rgb %0d,%0d,%0d last %0b", what,
                     want.row, want.first, want.last, want.red, want.green, want.blue, want.fin);
            $display("    got row %0d cols %0d..%0d rgb %0d,%0d,%0d last %0b",
                     got.row, got.first, got.last, got.red, got.green, got.blue, got.fin);
        end
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        stim_row_t e;
        e = '{check: SPANS_NONE, default: 0};
        e.is_write  = 1'b1;
        e.reg_index = idx;
        e.reg_value = val;
        e.check     = SPANS_NONE;
        stim_table.push_back(e);
    endfunction

    function automatic void add_point(input int cx, cy, input logic [COLOR_W-1:0] red, green,
                                      blue, input span_check_t check, input int row = 0,
                                      input int first = 0, input int last = 0);
        stim_row_t e;
        e = '{check: SPANS_NONE, default: 0};
        e.cx    = cx[IN_W-1:0];
        e.cy    = cy[IN_W-1:0];
        e.red   = red;
        e.green = green;
        e.blue  = blue;
        e.check = check;
        e.row   = row;
        e.first = first;
        e.last  = last;
        stim_table.push_back(e);
    endfunction

    // Presents one point, optionally after an idle gap, and waits until it is taken.
    task automatic send_point(input logic signed [IN_W-1:0] cx, cy,
                              input logic [COLOR_W-1:0] red, green, blue, input int gap,
                              input span_check_t check, input int row, first, last);
        disc_span_t s;
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        center_x    <= cx;
        center_y    <= cy;
        color_red   <= red;
        color_green <= green;
        color_blue  <= blue;
        do @(posedge clk); while (busy);
        points_sent++;
        case (check)
            SPANS_PREDICTED: predict_disc_spans(cx, cy, red, green, blue);
            SPANS_ONE:
            begin
                s.row   = row[SPAN_W-1:0];
                s.first = first[SPAN_W-1:0];
                s.last  = last[SPAN_W-1:0];
                s.red   = red;
                s.green = green;
                s.blue  = blue;
                s.fin   = 1'b1;
                pending_spans.push_back(s);
            end
            default: ;
        endcase
    endtask

    // Registers may change only once the block has gone idle. A point that yields no
    // span can still be in flight, so a full disc time passes after the last span.
    task automatic settle();
        start     <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The valid line is left high; the next point or settle lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
        case (idx)
            CFG_RADIUS: radius_q = val[RADIUS_W-1:0];
            CFG_WIDTH:  width_q  = val;
            CFG_HEIGHT: height_q = val;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin : span_check
        disc_span_t got;
        disc_span_t want;
        if (rst_n && span_valid)
        begin
            got = '{span_row, span_first, span_final, span_red, span_green, span_blue,
                    final_span};
            if (pending_spans.size() == 0)
                note_mismatch("span with nothing expected", '0, got);
            else
            begin
                want = pending_spans.pop_front();
                spans_checked++;
                if (got !== want)
                    note_mismatch("span mismatch", want, got);
            end
        end
    end

    initial
    begin
        int idle_pct;
        int gap;
        int w_eff;
        int h_eff;
        int pos;
        bit last_was_write;
        logic signed [IN_W-1:0] cx;
        logic signed [IN_W-1:0] cy;
        logic [CFG_W-1:0] val;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        center_x    <= '0;
        center_y    <= '0;
        color_red   <= '0;
        color_green <= '0;
        color_blue  <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_RADIUS;
        cfg_data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: radius 1 draws a single pixel in a 640 x 480 frame.
        add_point(0, 0, 8'h00, 8'h00, 8'h00, SPANS_ONE, 0, 0, 0);
        add_point(8, 8, 8'hFF, 8'hFF, 8'hFF, SPANS_ONE, 1, 1, 1);
        add_point(-8, 0, 8'h12, 8'h34, 8'h56, SPANS_NONE);
        add_point(-7, -7, 8'h80, 8'h01, 8'h7F, SPANS_ONE, 0, 0, 0);
        add_point(65535, 65535, 8'h55, 8'hAA, 8'h55, SPANS_NONE);
        add_point(-65536, -65536, 8'hAA, 8'h55, 8'hAA, SPANS_NONE);
        add_point(639 * 16, 479 * 16, 8'hA5, 8'h5A, 8'hC3, SPANS_ONE, 479, 639, 639);
        add_point(640 * 16, 100 * 16, 8'h11, 8'h22, 8'h33, SPANS_NONE);
        // A radius of zero behaves like radius 1.
        add_reg(CFG_RADIUS, 11'd0);
        add_point(100 * 16, 50 * 16, 8'h0F, 8'hF0, 8'h3C, SPANS_ONE, 50, 100, 100);
        add_reg(CFG_RADIUS, 11'd31);
        add_point(320 * 16, 240 * 16, 8'h01, 8'h02, 8'h03, SPANS_PREDICTED);
        add_point(0, 0, 8'hFE, 8'hFD, 8'hFC, SPANS_PREDICTED);
        add_point(639 * 16 + 7, 479 * 16 - 8, 8'h77, 8'h88, 8'h99, SPANS_PREDICTED);
        // Upper data bits of the radius register are dropped.
        add_reg(CFG_RADIUS, 11'h7E5);
        add_point(2 * 16, 2 * 16, 8'h40, 8'h41, 8'h42, SPANS_PREDICTED);
        add_reg(CFG_WIDTH, 11'd0);
        add_point(5 * 16, 5 * 16, 8'h10, 8'h20, 8'h30, SPANS_NONE);
        // Oversized frame saturates to the largest frame.
        add_reg(CFG_WIDTH, 11'h7FF);
        add_reg(CFG_HEIGHT, 11'h7FF);
        add_point(1023 * 16, 1023 * 16, 8'hC0, 8'hC1, 8'hC2, SPANS_PREDICTED);
        add_point(1030 * 16, 1020 * 16, 8'hD0, 8'hD1, 8'hD2, SPANS_PREDICTED);
        add_reg(CFG_WIDTH, 11'd1);
        add_reg(CFG_HEIGHT, 11'd1);
        add_point(0, 0, 8'h61, 8'h62, 8'h63, SPANS_ONE, 0, 0, 0);
        add_reg(CFG_HEIGHT, 11'd0);
        add_point(0, 0, 8'h71, 8'h72, 8'h73, SPANS_NONE);
        add_reg(CFG_RADIUS, 11'd30);
        add_reg(CFG_WIDTH, 11'd1024);
        add_reg(CFG_HEIGHT, 11'd1024);
        add_point(512 * 16 - 1, 3 * 16, 8'h90, 8'h91, 8'h92, SPANS_PREDICTED);
        add_point(-20 * 16, 1010 * 16, 8'hE0, 8'hE1, 8'hE2, SPANS_PREDICTED);

        last_was_write = 1'b0;
        foreach (stim_table[i])
        begin
            if (stim_table[i].is_write)
            begin
                if (!last_was_write)
                    settle();
                write_reg(stim_table[i].reg_index, stim_table[i].reg_value);
                last_was_write = 1'b1;
            end
            else
            begin
                send_point(stim_table[i].cx, stim_table[i].cy, stim_table[i].red,
                           stim_table[i].green, stim_table[i].blue, 0, stim_table[i].check,
                           stim_table[i].row, stim_table[i].first, stim_table[i].last);
                last_was_write = 1'b0;
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 74;
                default: idle_pct = 24;
            endcase
            settle();

            val = CFG_W'($urandom());
            case (ph)
                0: val[RADIUS_W-1:0] = 5'd31;
                1: val[RADIUS_W-1:0] = 5'd1;
                default: val[RADIUS_W-1:0] = RADIUS_W'($urandom_range(0, RADIUS_LIMIT));
            endcase
            write_reg(CFG_RADIUS, val);
            case ($urandom_range(0, 4))
                0: val = CFG_W'($urandom_range(FRAME_LIMIT + 1, 2047));
                1: val = 11'd1;
                2: val = CFG_W'(FRAME_LIMIT);
                default: val = CFG_W'($urandom_range(1, 700));
            endcase
            write_reg(CFG_WIDTH, val);
            case ($urandom_range(0, 4))
                0: val = CFG_W'($urandom_range(FRAME_LIMIT + 1, 2047));
                1: val = 11'd1;
                2: val = CFG_W'(FRAME_LIMIT);
                default: val = CFG_W'($urandom_range(1, 700));
            endcase
            write_reg(CFG_HEIGHT, val);

            w_eff = (width_q > FRAME_LIMIT) ? FRAME_LIMIT : int'(width_q);
            h_eff = (height_q > FRAME_LIMIT) ? FRAME_LIMIT : int'(height_q);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                gap = 0;
                if ($urandom_range(0, 99) < idle_pct)
                    gap = $urandom_range(1, 2 * radius_q + 12);
                // Most centers land in or near the frame; a few span the whole input range.
                if ($urandom_range(0, 9) == 0)
                begin
                    cx = IN_W'($urandom());
                    cy = IN_W'($urandom());
                end
                else
                begin
                    pos = int'($urandom_range(0, w_eff + 80)) - 40;
                    cx  = IN_W'(pos * SUB_PIXEL + int'($urandom_range(0, 15)) - 8);
                    pos = int'($urandom_range(0, h_eff + 80)) - 40;
                    cy  = IN_W'(pos * SUB_PIXEL + int'($urandom_range(0, 15)) - 8);
                end
                send_point(cx, cy, COLOR_W'($urandom()), COLOR_W'($urandom()),
                           COLOR_W'($urandom()), gap, SPANS_PREDICTED, 0, 0, 0);
            end
        end

        settle();
        $display("Sent %0d points over %0d register writes; %0d spans checked.",
                 points_sent, reg_writes, spans_checked);
        $display("Covered radii 0..31, saturated, unit and empty frames, and edge clipping.");
        if (error_count == 0 && pending_spans.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Timed out with %0d spans still expected.", pending_spans.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
